/* src/bir_pkg.sv */
// Shared constants, codes and types of the bilinear image rotator.
package bir_pkg;

    // Frame geometry and fixed-point format
    localparam int ROW_W     = 9;
    localparam int COL_W     = 9;
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 10;
    localparam int ANG_W     = 16;
    localparam int FRAC_BITS = 14;
    localparam int MAX_ROWS  = 1 << ROW_W;
    localparam int MAX_COLS  = 1 << COL_W;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Datapath widths
    localparam int DELTA_W = ROW_W + 1;
    localparam int MUL_A_W = 24;
    localparam int MUL_P_W = MUL_A_W + ANG_W;
    localparam int SR_W    = 30;
    localparam int INT_W   = SR_W - FRAC_BITS;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int TOP_W   = PIX_W + WGT_W;

    // Port widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Input word kinds
    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_CHECK,
        ST_FETCH,
        ST_BLEND,
        ST_RESULT
    } state_t;

endpackage

/* src/bilinear_image_rotator.sv */
// Top level of the bilinear image rotator: frame store, sequencer and shared multiplier.
// A store word writes one pixel into a 512x512 byte frame store.
// A request word maps the target point back through the configured rotation and
// returns one interpolated byte, zero when the point is outside, and s_tready stays
// low until the result has moved to the output register. A request is served by
// one 24x16 signed multiplier that runs four rotation products, then four neighbor
// weightings, then two row blends, and by the frame store, whose read port returns
// one neighbor per cycle. The frame store holds no reset value; reading a pixel
// that was never written gives an undefined byte.
module bilinear_image_rotator
    import bir_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // row[8:0], col[17:9], pixel_in[25:18], zero pad
    input  logic                 s_tuser,   // command
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // pixel_out[7:0]
    output logic                 m_tuser    // outside
);

    // Configuration registers
    logic [ROW_W-1:0]        center_row_reg;
    logic [COL_W-1:0]        center_col_reg;
    logic signed [ANG_W-1:0] cos_reg;
    logic signed [ANG_W-1:0] sin_reg;
    logic [DIM_W-1:0]        image_height_reg;
    logic [DIM_W-1:0]        image_width_reg;

    // Sequencer and datapath registers
    state_t                      state_reg, state_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic signed [DELTA_W-1:0]   dr_reg, dr_next;
    logic signed [DELTA_W-1:0]   dc_reg, dc_next;
    logic signed [MUL_P_W-1:0]   acc_reg, acc_next;
    logic signed [SR_W-1:0]      sr_reg, sr_next;
    logic signed [SR_W-1:0]      sc_reg, sc_next;
    logic [TOP_W-1:0]            top_reg, top_next;
    logic [PIX_W-1:0]            res_pix_reg, res_pix_next;
    logic                        res_out_reg, res_out_next;
    logic                        m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]            m_pix_reg, m_pix_next;
    logic                        m_out_reg, m_out_next;

    // Frame store
    logic [PIX_W-1:0]  frame_mem [MEM_DEPTH];
    logic [PIX_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    // Input word fields
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    logic [PIX_W-1:0] in_pix;
    logic             in_accept;
    logic             out_free;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [ANG_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    // Mapped point split and weights
    logic signed [INT_W-1:0] ir, ic;
    logic [FRAC_BITS-1:0]    fr, fc;
    logic [WGT_W-1:0]        wr0, wr1, wc0, wc1;
    logic [DIM_W-1:0]        h_sat, w_sat;
    logic signed [INT_W:0]   ir_p1, ic_p1, h_ext, w_ext;
    logic                    point_out;
    logic [ROW_W-1:0]        fetch_row;
    logic [COL_W-1:0]        fetch_col;

    assign in_row    = s_tdata[ROW_W-1:0];
    assign in_col    = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_pix    = s_tdata[ADDR_W+PIX_W-1:ADDR_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tuser  = m_out_reg;

    // Split the mapped point into floor and fraction
    assign ir  = sr_reg[SR_W-1:FRAC_BITS];
    assign ic  = sc_reg[SR_W-1:FRAC_BITS];
    assign fr  = sr_reg[FRAC_BITS-1:0];
    assign fc  = sc_reg[FRAC_BITS-1:0];
    assign wr1 = {1'b0, fr};
    assign wc1 = {1'b0, fc};
    assign wr0 = WGT_W'(1 << FRAC_BITS) - wr1;
    assign wc0 = WGT_W'(1 << FRAC_BITS) - wc1;

    // Clamp the image size and test the point and its +1 neighbor
    assign h_sat = (image_height_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : image_height_reg;
    assign w_sat = (image_width_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : image_width_reg;
    assign ir_p1 = {ir[INT_W-1], ir} + (INT_W+1)'(1);
    assign ic_p1 = {ic[INT_W-1], ic} + (INT_W+1)'(1);
    assign h_ext = {{(INT_W+1-DIM_W){1'b0}}, h_sat};
    assign w_ext = {{(INT_W+1-DIM_W){1'b0}}, w_sat};
    assign point_out = ir[INT_W-1] || (ir_p1 >= h_ext) || ic[INT_W-1] || (ic_p1 >= w_ext);

    // Neighbor address: row offset from count bit 1, column offset from bit 0
    assign fetch_row = ir[ROW_W-1:0] + ROW_W'(cnt_reg[1]);
    assign fetch_col = ic[COL_W-1:0] + COL_W'(cnt_reg[0]);
    assign rd_addr   = {fetch_row, fetch_col};

    assign mul_p = mul_a * mul_b;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_row_reg   <= ROW_W'(256);
            center_col_reg   <= COL_W'(256);
            cos_reg          <= ANG_W'(16384);
            sin_reg          <= '0;
            image_height_reg <= DIM_W'(512);
            image_width_reg  <= DIM_W'(512);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_ROW:   center_row_reg   <= cfg_data[ROW_W-1:0];
                REG_CENTER_COL:   center_col_reg   <= cfg_data[COL_W-1:0];
                REG_COS_ANGLE:    cos_reg          <= cfg_data;
                REG_SIN_ANGLE:    sin_reg          <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame store: write on a store word, read the neighbor address every cycle
    always_ff @(posedge aclk) begin
        if (in_accept && s_tuser == CMD_STORE) begin
            frame_mem[{in_row, in_col}] <= in_pix;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_tuser == CMD_REQUEST) state_next = ST_ROT;
            end
            ST_ROT: begin
                if (cnt_reg == 3'd3) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = point_out ? ST_RESULT : ST_FETCH;
            end
            ST_FETCH: begin
                if (cnt_reg == 3'd4) state_next = ST_BLEND;
            end
            ST_BLEND: begin
                if (cnt_reg == 3'd1) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        cnt_next     = cnt_reg + 3'd1;
        dr_next      = dr_reg;
        dc_next      = dc_reg;
        acc_next     = acc_reg;
        sr_next      = sr_reg;
        sc_next      = sc_reg;
        top_next     = top_reg;
        res_pix_next = res_pix_reg;
        res_out_next = res_out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_pix_next   = m_pix_reg;
        m_out_next   = m_out_reg;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                // Latch offsets from the rotation center
                cnt_next = '0;
                dr_next  = $signed({1'b0, in_row}) - $signed({1'b0, center_row_reg});
                dc_next  = $signed({1'b0, in_col}) - $signed({1'b0, center_col_reg});
            end
            ST_ROT: begin
                // Four products: cos*dr, sin*dc, cos*dc, sin*dr
                mul_a = (cnt_reg == 3'd0 || cnt_reg == 3'd3) ? MUL_A_W'(dr_reg)
                                                              : MUL_A_W'(dc_reg);
                mul_b = (cnt_reg == 3'd0 || cnt_reg == 3'd2) ? cos_reg : sin_reg;
                case (cnt_reg[1:0])
                    2'd0: acc_next = $signed(MUL_P_W'({center_row_reg, {FRAC_BITS{1'b0}}}))
                                     + mul_p;
                    2'd1: sr_next  = SR_W'(acc_reg - mul_p);
                    2'd2: acc_next = $signed(MUL_P_W'({center_col_reg, {FRAC_BITS{1'b0}}}))
                                     + mul_p;
                    default: sc_next = SR_W'(acc_reg + mul_p);
                endcase
            end
            ST_CHECK: begin
                // Outside points finish at once with zero
                cnt_next     = '0;
                res_pix_next = '0;
                res_out_next = point_out;
            end
            ST_FETCH: begin
                // Weight each neighbor by its column fraction as it arrives
                mul_a = MUL_A_W'(rd_data_reg);
                mul_b = cnt_reg[0] ? ANG_W'(wc0) : ANG_W'(wc1);
                if (cnt_reg != 3'd0) begin
                    if (cnt_reg[0]) begin
                        acc_next = mul_p;
                    end else begin
                        acc_next = acc_reg + mul_p;
                    end
                    if (cnt_reg == 3'd2) top_next = TOP_W'(acc_reg + mul_p);
                end
                if (cnt_reg == 3'd4) cnt_next = '0;
            end
            ST_BLEND: begin
                // Blend bottom and top rows by the row fraction
                if (cnt_reg == 3'd0) begin
                    mul_a    = MUL_A_W'(acc_reg[TOP_W-1:0]);
                    mul_b    = ANG_W'(wr1);
                    acc_next = mul_p;
                end else begin
                    mul_a        = MUL_A_W'(top_reg);
                    mul_b        = ANG_W'(wr0);
                    acc_next     = acc_reg + mul_p;
                    res_pix_next = acc_next[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
                    res_out_next = 1'b0;
                end
            end
            ST_RESULT: begin
                // Hand the result over when the output register is free
                cnt_next = '0;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_pix_next   = res_pix_reg;
                    m_out_next   = res_out_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        dr_reg      <= dr_next;
        dc_reg      <= dc_next;
        acc_reg     <= acc_next;
        sr_reg      <= sr_next;
        sc_reg      <= sc_next;
        top_reg     <= top_next;
        res_pix_reg <= res_pix_next;
        res_out_reg <= res_out_next;
        m_pix_reg   <= m_pix_next;
        m_out_reg   <= m_out_next;
    end

    // An outside result always carries a zero pixel
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("outside result with nonzero pixel");

    // A request starts the rotation at its first product
    a_request_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_tuser == CMD_REQUEST |=> state_reg == ST_ROT && cnt_reg == 3'd0)
        else $error("request did not start rotation");

    // A store keeps the block ready
    a_store_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_tuser == CMD_STORE |=> s_tready)
        else $error("store word stalled input");

    // The neighbor fetch never runs past its last read
    a_fetch_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |-> cnt_reg <= 3'd4)
        else $error("fetch count overrun");

endmodule

/* bench/tb.sv */
// Self-checking testbench for the bilinear image rotator: stream driver, monitor and predictor.
`timescale 1ns / 1ps

module tb
    import bir_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam int SHOW_LIMIT    = 20;

    typedef struct packed {
        logic             cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
    } stim_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             outside;
    } pixel_result_t;

    typedef struct packed {
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic [ANG_W-1:0] cos_v;
        logic [ANG_W-1:0] sin_v;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
    } rot_cfg_t;

    localparam rot_cfg_t RESET_CFG = '{
        center_row: 9'd256, center_col: 9'd256, cos_v: 16'd16384, sin_v: 16'd0,
        height: 10'd512, width: 10'd512
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // row[8:0], col[17:9], pixel_in[25:18], zero pad
    logic                 s_tuser;   // command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // pixel_out[7:0]
    logic                 m_tuser;   // outside

    // Stimulus and prediction state
    stim_word_t    word_backlog[$];
    pixel_result_t pixel_due[$];
    rot_cfg_t      rot_cfg;
    logic [PIX_W-1:0] frame_copy [MEM_DEPTH];
    bit            planned_written [MEM_DEPTH];

    bit s_fire;
    bit jitter_on;
    int gap_left;
    int stall_left;
    int cycle_count;
    int n_errors;
    int n_checked;
    int n_stores;
    int n_requests;
    int n_outside;
    int n_settings;

    bilinear_image_rotator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Map a target point back through the rotation; report floor parts and fractions
    function automatic void map_point(input rot_cfg_t c, input logic [ROW_W-1:0] row,
                                      input logic [COL_W-1:0] col, output bit in_frame,
                                      output int ir, output int ic,
                                      output longint fr, output longint fc);
        longint dr, dc, sr, sc, cs, sn, hh, ww, frac_mask;
        dr = longint'(row) - longint'(c.center_row);
        dc = longint'(col) - longint'(c.center_col);
        cs = longint'($signed(c.cos_v));
        sn = longint'($signed(c.sin_v));
        sr = -sn * dc + cs * dr + (longint'(c.center_row) << FRAC_BITS);
        sc = cs * dc + sn * dr + (longint'(c.center_col) << FRAC_BITS);
        frac_mask = (longint'(1) << FRAC_BITS) - 1;
        ir = int'(sr >>> FRAC_BITS);
        ic = int'(sc >>> FRAC_BITS);
        fr = sr & frac_mask;
        fc = sc & frac_mask;
        hh = (c.height > MAX_ROWS) ? MAX_ROWS : longint'(c.height);
        ww = (c.width > MAX_COLS) ? MAX_COLS : longint'(c.width);
        in_frame = !(ir < 0 || ir + 1 >= hh || ic < 0 || ic + 1 >= ww);
    endfunction

    // Expected output of one request, from the mirrored frame and settings
    function automatic pixel_result_t rotate_sample(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        pixel_result_t res;
        bit in_frame;
        int ir, ic;
        longint fr, fc, unit, p1, p2, p3, p4, sum;
        map_point(rot_cfg, row, col, in_frame, ir, ic, fr, fc);
        unit = longint'(1) << FRAC_BITS;
        if (!in_frame) begin
            res.pixel = '0;
            res.outside = 1'b1;
        end else begin
            p1 = longint'(frame_copy[ir * MAX_COLS + ic]);
            p2 = longint'(frame_copy[ir * MAX_COLS + ic + 1]);
            p3 = longint'(frame_copy[(ir + 1) * MAX_COLS + ic + 1]);
            p4 = longint'(frame_copy[(ir + 1) * MAX_COLS + ic]);
            sum = p1 * (unit - fc) * (unit - fr) + p2 * fc * (unit - fr)
                + p3 * fc * fr + p4 * (unit - fc) * fr;
            res.pixel = PIX_W'(sum >> (2 * FRAC_BITS));
            res.outside = 1'b0;
        end
        return res;
    endfunction

    // A request may go out only if every neighbor it reads has been stored
    function automatic bit request_is_safe(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col);
        bit in_frame;
        int ir, ic;
        longint fr, fc;
        map_point(rot_cfg, row, col, in_frame, ir, ic, fr, fc);
        if (!in_frame) return 1'b1;
        return planned_written[ir * MAX_COLS + ic] && planned_written[ir * MAX_COLS + ic + 1]
            && planned_written[(ir + 1) * MAX_COLS + ic]
            && planned_written[(ir + 1) * MAX_COLS + ic + 1];
    endfunction

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (!jitter_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [ROW_W-1:0] clamp_coord(input int v);
        if (v < 0) return '0;
        if (v > MAX_ROWS - 1) return ROW_W'(MAX_ROWS - 1);
        return ROW_W'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < SHOW_LIMIT) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        n_errors++;
    endtask

    task automatic add_word(input logic cmd, input int row, input int col, input int pix);
        stim_word_t w;
        w.cmd = cmd;
        w.row = ROW_W'(row);
        w.col = COL_W'(col);
        w.pixel = PIX_W'(pix);
        if (cmd == CMD_STORE) planned_written[row * MAX_COLS + col] = 1'b1;
        word_backlog.push_back(w);
    endtask

    // Hold until all words are taken and every result is back, then let the pipe settle
    task automatic wait_drained();
        while (word_backlog.size() != 0 || s_tvalid || pixel_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
    endtask

    task automatic set_config(input int cr, input int cc, input int cv, input int sv,
                              input int h, input int w);
        wait_drained();
        write_reg(REG_CENTER_ROW, CFG_W'(cr));
        write_reg(REG_CENTER_COL, CFG_W'(cc));
        write_reg(REG_COS_ANGLE, CFG_W'(cv));
        write_reg(REG_SIN_ANGLE, CFG_W'(sv));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        @(negedge aclk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // One setting: fill a small window around the center, then mostly requests into it
    task automatic random_phase(input int ph);
        int n, r0, c0, cr, cc, cv, sv, h, w, k, pick, tries;
        logic [ROW_W-1:0] tr;
        logic [COL_W-1:0] tc;
        real ang;
        bit sent;
        n = $urandom_range(4, 12);
        r0 = $urandom_range(0, MAX_ROWS - n);
        c0 = $urandom_range(0, MAX_COLS - n);
        if (ph == 0) begin
            r0 = 0;
            c0 = 0;
        end else if (ph == 1) begin
            r0 = MAX_ROWS - n;
            c0 = MAX_COLS - n;
        end
        cr = r0 + n / 2;
        cc = c0 + n / 2;
        case (ph % 4)
            1: begin
                k = $urandom_range(0, 3);
                cv = (k == 0) ? 16384 : (k == 2) ? -16384 : 0;
                sv = (k == 1) ? 16384 : (k == 3) ? -16384 : 0;
            end
            2: begin
                cv = (ph == 2) ? -32768 : $urandom_range(0, 65535);
                sv = (ph == 2) ? 32767 : $urandom_range(0, 65535);
            end
            default: begin
                ang = $urandom_range(0, 359) * 3.14159265 / 180.0;
                cv = $rtoi($floor(16384.0 * $cos(ang) + 0.5));
                sv = $rtoi($floor(16384.0 * $sin(ang) + 0.5));
            end
        endcase
        case ($urandom_range(0, 3))
            2: begin
                h = r0 + n;
                w = c0 + n;
            end
            3: begin
                h = $urandom_range(0, 1023);
                w = $urandom_range(0, 1023);
            end
            default: begin
                h = MAX_ROWS;
                w = MAX_COLS;
            end
        endcase
        if (ph == 1) begin
            h = MAX_ROWS;
            w = MAX_COLS;
        end
        jitter_on = (ph != 3);
        set_config(cr, cc, cv, sv, h, w);

        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                add_word(CMD_STORE, r0 + r, c0 + c, $urandom_range(0, 255));

        for (int i = 0; i < 140; i++) begin
            pick = $urandom_range(0, 99);
            sent = 1'b0;
            if (pick < 70) begin
                // retry until every neighbor read is known; fall back to a store
                for (tries = 0; tries < 8 && !sent; tries++) begin
                    if (pick < 60) begin
                        tr = clamp_coord(cr + int'($urandom_range(0, n)) - n / 2);
                        tc = clamp_coord(cc + int'($urandom_range(0, n)) - n / 2);
                    end else begin
                        tr = ROW_W'($urandom_range(0, MAX_ROWS - 1));
                        tc = COL_W'($urandom_range(0, MAX_COLS - 1));
                    end
                    if (request_is_safe(tr, tc)) begin
                        add_word(CMD_REQUEST, tr, tc, $urandom_range(0, 255));
                        sent = 1'b1;
                    end
                end
            end
            if (!sent) begin
                if (pick < 85)
                    add_word(CMD_STORE, r0 + $urandom_range(0, n - 1),
                             c0 + $urandom_range(0, n - 1), $urandom_range(0, 255));
                else
                    add_word(CMD_STORE, $urandom_range(0, MAX_ROWS - 1),
                             $urandom_range(0, MAX_COLS - 1), $urandom_range(0, 255));
            end
        end
    endtask

    // Input driver: present the next word after acceptance or a gap
    always @(negedge aclk) begin : word_driver
        stim_word_t w;
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (word_backlog.size() > 0) begin
                w = word_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= w.cmd;
                s_tdata <= {{(S_TDATA_W - PIX_W - COL_W - ROW_W){1'b0}}, w.pixel, w.col, w.row};
                gap_left = idle_span();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls on m_tready
    always @(negedge aclk) begin : result_sink
        if (!jitter_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            stall_left = idle_span();
            m_tready <= 1'b0;
        end
    end

    // Monitor: mirror settings and frame, predict on accepted words, check results
    always @(posedge aclk) begin : monitor
        pixel_result_t want;
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            s_fire <= 1'b0;
            rot_cfg <= RESET_CFG;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CENTER_ROW:   rot_cfg.center_row <= cfg_data[ROW_W-1:0];
                    REG_CENTER_COL:   rot_cfg.center_col <= cfg_data[COL_W-1:0];
                    REG_COS_ANGLE:    rot_cfg.cos_v <= cfg_data[ANG_W-1:0];
                    REG_SIN_ANGLE:    rot_cfg.sin_v <= cfg_data[ANG_W-1:0];
                    REG_IMAGE_HEIGHT: rot_cfg.height <= cfg_data[DIM_W-1:0];
                    REG_IMAGE_WIDTH:  rot_cfg.width <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_STORE) begin
                    frame_copy[{s_tdata[ROW_W-1:0], s_tdata[ROW_W+COL_W-1:ROW_W]}] =
                        s_tdata[ROW_W+COL_W+PIX_W-1:ROW_W+COL_W];
                    n_stores++;
                end else begin
                    want = rotate_sample(s_tdata[ROW_W-1:0], s_tdata[ROW_W+COL_W-1:ROW_W]);
                    pixel_due.push_back(want);
                    n_requests++;
                    if (want.outside) n_outside++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (pixel_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word pixel=%0d outside=%0b",
                                              m_tdata, m_tuser));
                end else begin
                    want = pixel_due.pop_front();
                    n_checked++;
                    if (m_tdata !== want.pixel)
                        report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                                  m_tdata, want.pixel));
                    if (m_tuser !== want.outside)
                        report_mismatch($sformatf("outside %0b, expected %0b",
                                                  m_tuser, want.outside));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 pixel_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_STORE;
        m_tready = 1'b0;
        jitter_on = 1'b1;
        gap_left = 0;
        stall_left = 0;
        cycle_count = 0;
        n_errors = 0;
        n_checked = 0;
        n_stores = 0;
        n_requests = 0;
        n_outside = 0;
        n_settings = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: identity about the middle, full frame; corner pixels
        add_word(CMD_STORE, 0, 0, 255);
        add_word(CMD_STORE, 0, 1, 0);
        add_word(CMD_STORE, 1, 0, 0);
        add_word(CMD_STORE, 1, 1, 255);
        add_word(CMD_STORE, 510, 510, 1);
        add_word(CMD_STORE, 510, 511, 254);
        add_word(CMD_STORE, 511, 510, 127);
        add_word(CMD_STORE, 511, 511, 170);
        add_word(CMD_REQUEST, 0, 0, 0);
        add_word(CMD_REQUEST, 510, 510, 255);
        // +1 neighbor beyond the last row or column
        add_word(CMD_REQUEST, 511, 511, 0);
        add_word(CMD_REQUEST, 0, 511, 0);
        add_word(CMD_REQUEST, 511, 0, 0);

        // Zero height: every point outside; oversized width saturates
        set_config(256, 256, 16384, 0, 0, 1023);
        add_word(CMD_REQUEST, 0, 0, 0);
        set_config(256, 256, 16384, 0, 1023, 1023);
        add_word(CMD_REQUEST, 510, 510, 0);
        add_word(CMD_REQUEST, 511, 511, 0);
        set_config(256, 256, 16384, 0, 1, 512);
        add_word(CMD_REQUEST, 0, 0, 0);

        // Half scale about the origin gives half-pixel blends that truncate
        set_config(0, 0, 8192, 0, 512, 512);
        add_word(CMD_REQUEST, 1, 1, 0);
        add_word(CMD_REQUEST, 0, 1, 0);
        add_word(CMD_REQUEST, 1, 0, 0);

        // Quarter and half turns about the far corners
        set_config(0, 511, 0, 16384, 512, 512);
        add_word(CMD_REQUEST, 0, 0, 0);
        set_config(511, 511, -16384, 0, 512, 512);
        add_word(CMD_REQUEST, 511, 511, 0);

        for (int ph = 0; ph < 8; ph++)
            random_phase(ph);

        jitter_on = 1'b1;
        wait_drained();
        $display("ran %0d settings: %0d stores, %0d requests, %0d of them outside",
                 n_settings, n_stores, n_requests, n_outside);
        $display("compared %0d results, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* bilinear_image_rotator.f */
src/bir_pkg.sv
src/bilinear_image_rotator.sv
bench/tb.sv
